### src/array_bag_stack_assert.svh
// Assertion macros for the array bag/stack block.
// Depends on nothing; included by files that check their own logic.
`ifndef ARRAY_BAG_STACK_ASSERT_SVH
`define ARRAY_BAG_STACK_ASSERT_SVH

`ifndef SYNTH
// expression must never hold outside reset
`define ABS_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("check failed: never");
// antecedent implies consequent in the same cycle
`define ABS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: implies");
// antecedent implies consequent in the next cycle
`define ABS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: next");
`else
`define ABS_ASSERT_NEVER(label, clk, rst_n, expr)
`define ABS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ABS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/abs_pkg.sv
// Shared types and constants for the array bag/stack block.
// No dependencies; used by the channel interfaces and the top level.
package abs_pkg;

  localparam int CMD_W         = 3;
  localparam int IN_VALUE_W    = 32;
  localparam int MATCH_IDX_W   = 6;
  localparam int ENTRY_COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 3'd0,
    CMD_CONTAINS = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_POP      = 3'd3,
    CMD_PEEK     = 3'd4
  } abs_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_TOP,
    ST_RESP
  } abs_state_t;

endpackage

### src/abs_if.sv
// Valid/ready channel interfaces for the array bag/stack block.
// Depends on abs_pkg for field widths.
interface abs_in_if import abs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              cmd;
  logic signed [IN_VALUE_W-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface abs_out_if import abs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic                          match_found;
  logic [MATCH_IDX_W-1:0]        match_index;
  logic signed [IN_VALUE_W-1:0]  top_value;
  logic [ENTRY_COUNT_W-1:0]      entry_count;
  logic                          is_empty;

  modport source (output valid, output accepted, output match_found, output match_index,
                  output top_value, output entry_count, output is_empty, input ready);
  modport sink   (input valid, input accepted, input match_found, input match_index,
                  input top_value, input entry_count, input is_empty, output ready);
endinterface

### src/array_bag_stack.sv
// Add, pop, peek and unused codes: the block passes ST_TOP, then ST_RESP, where the result
// loads. Contains and remove scan in ST_SEARCH, remove then shifts in ST_SHIFT, paced by the
// single read port of the entry memory (one entry read per cycle in scan and shift, tail read
// once). One transaction at a time; the next can be taken the cycle after the result loads.
// Reset (synchronous, active low) clears the count and control state; memory is not cleared.
// Depends on abs_pkg, abs_if.sv and array_bag_stack_assert.svh.
`include "array_bag_stack_assert.svh"

module array_bag_stack import abs_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  abs_in_if.sink        in_ch,
  abs_out_if.source     out_ch
);

  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MI_EXT_W = IDX_W + MATCH_IDX_W;
  localparam int EC_EXT_W = CNT_W + ENTRY_COUNT_W;

  // entry store, one write and one registered read port
  logic [VALUE_WIDTH-1:0] entries_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rdata_r;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]       mem_raddr;

  abs_state_t             state_r, state_nxt;
  abs_cmd_t               cmd_r, cmd_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       scan_r, scan_nxt;
  logic [IDX_W-1:0]       chk_r, chk_nxt;
  logic                   pend_r, pend_nxt;
  logic                   found_r, found_nxt;
  logic                   acc_r, acc_nxt;
  logic [IDX_W-1:0]       match_r, match_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_load;
  logic                   out_acc_r;
  logic                   out_found_r;
  logic [MATCH_IDX_W-1:0] out_idx_r;
  logic [IN_VALUE_W-1:0]  out_top_r;
  logic [ENTRY_COUNT_W-1:0] out_cnt_r;
  logic                   out_empty_r;

  logic                   in_fire;
  logic [63:0]            in_ext;
  logic [VALUE_WIDTH-1:0] in_val;
  logic [CNT_W-1:0]       cnt_m1;
  logic [CNT_W-1:0]       scan_m1;
  logic [IDX_W-1:0]       top_addr;
  logic                   hit;
  logic signed [VALUE_WIDTH-1:0] rd_signed;
  logic [63:0]            top_ext;
  logic [MI_EXT_W-1:0]    mi_ext;
  logic [EC_EXT_W-1:0]    ec_ext;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign in_ext   = 64'(in_ch.value);
  assign in_val   = in_ext[VALUE_WIDTH-1:0];
  assign cnt_m1   = cnt_r - 1'b1;
  assign scan_m1  = scan_r - 1'b1;
  assign top_addr = (cnt_r != '0) ? cnt_m1[IDX_W-1:0] : '0;
  assign hit      = pend_r && (rdata_r == val_r);

  assign rd_signed = rdata_r;
  assign top_ext   = 64'(rd_signed);
  assign mi_ext    = MI_EXT_W'(match_r);
  assign ec_ext    = EC_EXT_W'(cnt_r);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    scan_nxt  = scan_r;
    chk_nxt   = chk_r;
    pend_nxt  = 1'b0;
    found_nxt = found_r;
    acc_nxt   = acc_r;
    match_nxt = match_r;
    mem_we    = 1'b0;
    mem_waddr = cnt_r[IDX_W-1:0];
    mem_wdata = in_val;
    mem_raddr = top_addr;
    out_load  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = abs_cmd_t'(in_ch.cmd);
          val_nxt   = in_val;
          scan_nxt  = '0;
          found_nxt = 1'b0;
          acc_nxt   = 1'b0;
          match_nxt = '0;
          state_nxt = ST_TOP;
          unique case (abs_cmd_t'(in_ch.cmd))
            CMD_ADD: begin
              if (cnt_r < CNT_W'(CAPACITY)) begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                acc_nxt = 1'b1;
              end
            end
            CMD_CONTAINS, CMD_REMOVE: state_nxt = ST_SEARCH;
            CMD_POP: begin
              if (cnt_r != '0) begin
                cnt_nxt = cnt_m1;
                acc_nxt = 1'b1;
              end
            end
            CMD_PEEK: acc_nxt = 1'b1;
            default: ;
          endcase
        end
      end

      ST_SEARCH: begin
        // compare the entry read last cycle; with no hit, fetch the next one while any remain
        priority if (hit) begin
          found_nxt = 1'b1;
          acc_nxt   = 1'b1;
          match_nxt = chk_r;
          if (cmd_r == CMD_REMOVE) begin
            scan_nxt  = CNT_W'(chk_r) + 1'b1;
            state_nxt = ST_SHIFT;
          end else begin
            state_nxt = ST_TOP;
          end
        end else if (scan_r < cnt_r) begin
          mem_raddr = scan_r[IDX_W-1:0];
          pend_nxt  = 1'b1;
          chk_nxt   = scan_r[IDX_W-1:0];
          scan_nxt  = scan_r + 1'b1;
        end else begin
          state_nxt = ST_TOP;
        end
      end

      ST_SHIFT: begin
        // write the entry read last cycle one slot down
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = chk_r;
          mem_wdata = rdata_r;
        end
        priority if (scan_r < cnt_r) begin
          mem_raddr = scan_r[IDX_W-1:0];
          pend_nxt  = 1'b1;
          chk_nxt   = scan_m1[IDX_W-1:0];
          scan_nxt  = scan_r + 1'b1;
        end else if (!pend_r) begin
          cnt_nxt   = cnt_m1;
          state_nxt = ST_TOP;
        end else begin
          pend_nxt  = 1'b0;
        end
      end

      ST_TOP: state_nxt = ST_RESP;

      ST_RESP: begin
        // hold here while the previous result is still waiting
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entries_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= entries_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    val_r   <= val_nxt;
    scan_r  <= scan_nxt;
    chk_r   <= chk_nxt;
    found_r <= found_nxt;
    acc_r   <= acc_nxt;
    match_r <= match_nxt;
    if (out_load) begin
      out_acc_r   <= acc_r;
      out_found_r <= found_r;
      out_idx_r   <= found_r ? mi_ext[MATCH_IDX_W-1:0] : '0;
      out_top_r   <= (cnt_r != '0) ? top_ext[IN_VALUE_W-1:0] : '0;
      out_cnt_r   <= ec_ext[ENTRY_COUNT_W-1:0];
      out_empty_r <= (cnt_r == '0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = out_acc_r;
  assign out_ch.match_found = out_found_r;
  assign out_ch.match_index = out_idx_r;
  assign out_ch.top_value   = out_top_r;
  assign out_ch.entry_count = out_cnt_r;
  assign out_ch.is_empty    = out_empty_r;

  `ABS_ASSERT_NEVER(a_cnt_within_cap, clk, rst_n, (cnt_r > CNT_W'(CAPACITY)))
  `ABS_ASSERT_NEVER(a_write_only_idle_shift, clk, rst_n, (mem_we && (state_r != ST_IDLE) && (state_r != ST_SHIFT)))
  `ABS_ASSERT_IMPLIES(a_scan_in_range, clk, rst_n, ((state_r == ST_SEARCH) && pend_r), (CNT_W'(chk_r) < cnt_r))
  `ABS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, (state_r != ST_IDLE))

endmodule

### dv/tb_array_bag_stack.sv
// Self-checking testbench for array_bag_stack: directed corner cases, then random command phases.
// Predicts every status result in-bench and compares it field by field with the block's output.
// Depends on abs_pkg, abs_if.sv and the array_bag_stack RTL.
module tb_array_bag_stack;
  import abs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int N_RANDOM    = 1300;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PRINT_CAP   = 200;
  localparam logic [CMD_W-1:0] CMD_CODE_MAX = '1;

  typedef struct packed {
    logic                          accepted;
    logic                          match_found;
    logic [MATCH_IDX_W-1:0]        match_index;
    logic signed [IN_VALUE_W-1:0]  top_value;
    logic [ENTRY_COUNT_W-1:0]      entry_count;
    logic                          is_empty;
  } bag_status_t;

  typedef struct {
    logic [CMD_W-1:0]              op;
    logic signed [IN_VALUE_W-1:0]  value;
    int                            gap;
    bit                            drain;
  } bag_op_t;

  logic clk = 1'b0;
  logic rst_n;

  abs_in_if  in_ch();
  abs_out_if out_ch();

  array_bag_stack #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted store contents
  logic signed [IN_VALUE_W-1:0] bag_mem [CAPACITY];
  int bag_fill = 0;

  bag_op_t     op_queue[$];
  bag_status_t status_q[$];

  int launch_cnt = 0;
  int taken_cnt  = 0;
  int got_cnt    = 0;
  int seen_got   = 0;
  int gap_left   = 0;
  int stall_left = 0;
  int stall_draw;
  bit in_idle    = 1'b1;
  bit out_idle   = 1'b1;
  int mismatches = 0;
  int cycle_cnt  = 0;
  int peak_fill  = 0;
  int hit_cnt    = 0;
  int op_tally [2**CMD_W];

  function automatic bag_status_t bag_apply(logic [CMD_W-1:0] op,
                                            logic signed [IN_VALUE_W-1:0] v);
    bag_status_t st;
    int hit;
    st  = '0;
    hit = -1;
    if (op == CMD_CONTAINS || op == CMD_REMOVE) begin
      for (int i = 0; i < bag_fill; i++)
        if (hit < 0 && bag_mem[i] == v) hit = i;
    end
    case (op)
      CMD_ADD: begin
        if (bag_fill < CAPACITY) begin
          bag_mem[bag_fill] = v;
          bag_fill++;
          st.accepted = 1'b1;
        end
      end
      CMD_CONTAINS: st.accepted = (hit >= 0);
      CMD_REMOVE: begin
        if (hit >= 0) begin
          // close the gap left by the first match
          for (int i = hit; i + 1 < bag_fill; i++) bag_mem[i] = bag_mem[i + 1];
          bag_fill--;
          st.accepted = 1'b1;
        end
      end
      CMD_POP: begin
        if (bag_fill > 0) begin
          bag_fill--;
          st.accepted = 1'b1;
        end
      end
      CMD_PEEK: st.accepted = 1'b1;
      default: ;
    endcase
    st.match_found = (hit >= 0);
    st.match_index = (hit >= 0) ? MATCH_IDX_W'(hit) : '0;
    st.top_value   = (bag_fill > 0) ? bag_mem[bag_fill - 1] : '0;
    st.entry_count = ENTRY_COUNT_W'(bag_fill);
    st.is_empty    = (bag_fill == 0);
    return st;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, field, want, got);
      if (mismatches == PRINT_CAP)
        $display("%0t: further mismatch reports suppressed", $time);
    end
  endtask

  task automatic queue_op(logic [CMD_W-1:0] op, logic signed [IN_VALUE_W-1:0] v, bit drain);
    bag_op_t item;
    item.op    = op;
    item.value = v;
    item.gap   = in_idle ? $urandom_range(0, 7) : 0;
    item.drain = drain;
    op_queue.push_back(item);
  endtask

  // Input driver: launch on the falling edge, hold until the block takes it
  always @(negedge clk) begin
    if (rst_n) begin
      if (launch_cnt != taken_cnt) begin
        // hold transaction
      end else if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (op_queue.size() != 0 &&
                   !(op_queue[0].drain && status_q.size() != 0)) begin
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= op_queue[0].op;
        in_ch.value <= op_queue[0].value;
        gap_left    <= op_queue[0].gap;
        launch_cnt  <= launch_cnt + 1;
        void'(op_queue.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: draw a stall after each result
  always @(negedge clk) begin
    if (rst_n) begin
      if (got_cnt != seen_got) begin
        seen_got     = got_cnt;
        stall_draw   = out_idle ? $urandom_range(0, 7) : 0;
        out_ch.ready <= (stall_draw == 0);
        stall_left   <= (stall_draw == 0) ? 0 : stall_draw - 1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: check results, then predict for the accepted command
  always @(posedge clk) begin
    bag_status_t want;
    bag_status_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got_cnt <= got_cnt + 1;
        if (got_cnt % 50 == 49) out_idle <= ($urandom_range(0, 3) != 0);
        got = '{out_ch.accepted, out_ch.match_found, out_ch.match_index,
                out_ch.top_value, out_ch.entry_count, out_ch.is_empty};
        if (status_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, nothing expected, actual %0h", $time, got);
        end else begin
          want = status_q.pop_front();
          compare_field("accepted",    want.accepted,    got.accepted);
          compare_field("match_found", want.match_found, got.match_found);
          compare_field("match_index", want.match_index, got.match_index);
          compare_field("top_value",   want.top_value,   got.top_value);
          compare_field("entry_count", want.entry_count, got.entry_count);
          compare_field("is_empty",    want.is_empty,    got.is_empty);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        taken_cnt <= taken_cnt + 1;
        op_tally[in_ch.cmd]++;
        want = bag_apply(in_ch.cmd, in_ch.value);
        if (want.match_found) hit_cnt++;
        if (bag_fill > peak_fill) peak_fill = bag_fill;
        status_q.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d results outstanding",
               $time, CYCLE_LIMIT, status_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic signed [IN_VALUE_W-1:0] pool [6];
    int t_add [3];
    int t_con [3];
    int t_rem [3];
    int t_pop [3];
    int kind, len, r, phase, queued;
    logic [CMD_W-1:0] op;
    logic signed [IN_VALUE_W-1:0] v;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_PEEK;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    foreach (op_tally[i]) op_tally[i] = 0;

    // Directed: empty-store corners, unused codes, value extremes, duplicates
    queue_op(CMD_PEEK,     0, 1'b0);
    queue_op(CMD_POP,      0, 1'b0);
    queue_op(CMD_CONTAINS, 5, 1'b0);
    queue_op(CMD_REMOVE,   5, 1'b0);
    for (int c = CMD_PEEK + 1; c <= CMD_CODE_MAX; c++)
      queue_op(CMD_W'(c), 32'h1234_5678, 1'b0);
    queue_op(CMD_ADD,      32'h7FFF_FFFF, 1'b0);
    queue_op(CMD_ADD,      32'h8000_0000, 1'b0);
    queue_op(CMD_ADD,      0, 1'b0);
    queue_op(CMD_ADD,      -1, 1'b0);
    queue_op(CMD_ADD,      0, 1'b0);
    queue_op(CMD_CONTAINS, 0, 1'b0);
    queue_op(CMD_CONTAINS, 32'h8000_0000, 1'b0);
    queue_op(CMD_CONTAINS, 12345, 1'b0);
    queue_op(CMD_REMOVE,   0, 1'b0);
    queue_op(CMD_REMOVE,   32'h7FFF_FFFF, 1'b0);
    queue_op(CMD_PEEK,     0, 1'b0);
    queue_op(CMD_POP,      0, 1'b0);
    queue_op(CMD_POP,      0, 1'b0);
    queue_op(CMD_POP,      0, 1'b0);
    queue_op(CMD_POP,      0, 1'b0);
    queue_op(CMD_ADD,      32'h5555_5555, 1'b0);

    // Random phases cycle fill / drain / mixed; thresholds are cumulative percent
    t_add = '{80, 15, 35};
    t_con = '{88, 30, 55};
    t_rem = '{93, 65, 75};
    t_pop = '{96, 95, 90};
    queued = 0;
    phase  = 0;
    while (queued < N_RANDOM) begin
      kind    = phase % 3;
      len     = (kind == 0) ? $urandom_range(100, 140) : $urandom_range(40, 120);
      in_idle = ($urandom_range(0, 3) != 0);
      pool    = '{$urandom(), $urandom_range(0, 15), 32'h7FFF_FFFF, 32'h8000_0000,
                  $urandom(), -1};
      for (int k = 0; k < len && queued < N_RANDOM; k++) begin
        r = $urandom_range(0, 99);
        if (r < t_add[kind])      op = CMD_ADD;
        else if (r < t_con[kind]) op = CMD_CONTAINS;
        else if (r < t_rem[kind]) op = CMD_REMOVE;
        else if (r < t_pop[kind]) op = CMD_POP;
        else if (r < 98)          op = CMD_PEEK;
        else                      op = CMD_W'($urandom_range(CMD_PEEK + 1, CMD_CODE_MAX));
        v = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 5)] : $urandom();
        // let the store settle completely before each new phase
        queue_op(op, v, k == 0);
        queued++;
      end
      phase++;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || launch_cnt != taken_cnt || status_q.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d commands: add %0d, contains %0d, remove %0d, pop %0d, peek %0d, other %0d",
             taken_cnt, op_tally[CMD_ADD], op_tally[CMD_CONTAINS], op_tally[CMD_REMOVE],
             op_tally[CMD_POP], op_tally[CMD_PEEK], taken_cnt - op_tally[CMD_ADD]
             - op_tally[CMD_CONTAINS] - op_tally[CMD_REMOVE] - op_tally[CMD_POP]
             - op_tally[CMD_PEEK]);
    $display("Store reached %0d of %0d entries; %0d search hits; %0d mismatches",
             peak_fill, CAPACITY, hit_cnt, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
